### hw/rtl/pslm_pkg.sv
// ----------------------------------------------------------------------------
// pslm_pkg
// shared types and constants for the per-source sequence loss monitor
// ----------------------------------------------------------------------------
package pslm_pkg;

    localparam int NODE_W    = 6;
    localparam int SEQ_W     = 32;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = CNT_W + 1;
    localparam int FRAC_W    = 17;
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = 5;

    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // one table row per source
    typedef struct packed {
        logic [SEQ_W-1:0] expected;
        logic [CNT_W-1:0] lost;
        logic [CNT_W-1:0] received;
    } pslm_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } pslm_state_t;

    // divider status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } pslm_div_stat_t;

endpackage

### hw/rtl/pslm_ram.sv
// ----------------------------------------------------------------------------
// pslm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pslm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pslm_div.sv
// ----------------------------------------------------------------------------
// pslm_div
// restoring divider, one quotient bit per cycle: floor(lost * 2^16 / sum)
// ----------------------------------------------------------------------------
module pslm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pslm_pkg::CNT_W-1:0]       lost,
    input  logic [pslm_pkg::SUM_W-1:0]       sum,
    output pslm_pkg::pslm_div_stat_t         stat,
    output logic [pslm_pkg::FRAC_W-1:0]      quotient
);

    localparam int CW  = pslm_pkg::DIV_CNT_W;
    localparam int DW  = pslm_pkg::SUM_W;
    localparam int RW  = DW + 1;
    localparam int QW  = pslm_pkg::FRAC_W;

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [QW-1:0] q_reg, q_next;
    logic          last;
    logic          ge;
    logic [RW-1:0] rem_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign last = busy_reg && (cnt_reg == CW'(pslm_pkg::DIV_STEPS - 1));

    always_comb
    begin
        ge        = (rem_reg >= {1'b0, div_reg});
        rem_sub   = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {2'b00, lost};
            div_next  = sum;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so one shift keeps it in range
            rem_next = {rem_sub[RW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = last;
    assign quotient  = q_reg;

endmodule

### hw/rtl/per_source_sequence_loss_monitor.sv
// ----------------------------------------------------------------------------
// per_source_sequence_loss_monitor
// per-source packet loss counting from sequence gaps, with loss reports
// ----------------------------------------------------------------------------
// a data item is accepted with its table read, then modified and written back
// a report item is accepted with its table read, then takes one divider step per
// quotient bit and is emitted once the output is free; the next item follows it
// data items are accepted while a finished report still waits on the output
// after reset a clearing pass zeroes all SOURCES rows of the table, one row a
// cycle, with in_stall high; control state is cleared asynchronously by rst_n
module per_source_sequence_loss_monitor #(
    parameter int SOURCES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [pslm_pkg::NODE_W-1:0]      source_node,
    input  logic [pslm_pkg::SEQ_W-1:0]       sequence_number,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pslm_pkg::NODE_W-1:0]      report_node,
    output logic [pslm_pkg::CNT_W-1:0]       lost_total,
    output logic [pslm_pkg::CNT_W-1:0]       received_total,
    output logic [pslm_pkg::FRAC_W-1:0]      loss_fraction,
    output logic                             no_packets
);

    localparam int AW = $clog2(SOURCES);
    localparam int NW = pslm_pkg::NODE_W;
    localparam int EW = (AW > NW) ? AW : NW;
    localparam int SW = pslm_pkg::SEQ_W;
    localparam int CW = pslm_pkg::CNT_W;
    localparam int UW = pslm_pkg::SUM_W;
    localparam int FW = pslm_pkg::FRAC_W;
    localparam int TW = $bits(pslm_pkg::pslm_entry_t);

    // controller state
    pslm_pkg::pslm_state_t state_reg, state_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;

    // item held while it is worked on
    logic                  mode_reg, mode_next;
    logic [NW-1:0]         node_reg, node_next;
    logic [SW-1:0]         seq_reg, seq_next;
    logic                  range_reg, range_next;
    logic [AW-1:0]         addr_reg, addr_next;

    // report values captured at the read
    logic [CW-1:0]         rep_lost_reg, rep_lost_next;
    logic [CW-1:0]         rep_recv_reg, rep_recv_next;
    logic                  empty_reg, empty_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [NW-1:0]         o_node_reg, o_node_next;
    logic [CW-1:0]         o_lost_reg, o_lost_next;
    logic [CW-1:0]         o_recv_reg, o_recv_next;
    logic [FW-1:0]         o_frac_reg, o_frac_next;
    logic                  o_empty_reg, o_empty_next;

    // table port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    pslm_pkg::pslm_entry_t ram_wentry;
    logic [TW-1:0]         ram_rdata;
    pslm_pkg::pslm_entry_t rd_entry;
    logic [AW-1:0]         in_addr;
    logic [EW-1:0]         node_ext;
    logic                  in_range;
    logic                  accept;

    // divider
    logic                     div_start;
    logic [CW-1:0]            div_lost;
    logic [UW-1:0]            div_sum;
    pslm_pkg::pslm_div_stat_t div_stat;
    logic [FW-1:0]            div_q;

    // data item arithmetic
    logic [SW:0]           seq_diff;
    logic                  seq_ahead;
    logic [CW:0]           lost_add;
    logic [CW-1:0]         lost_sat;
    logic [CW-1:0]         recv_inc;
    logic [CW-1:0]         rd_lost_v;
    logic [CW-1:0]         rd_recv_v;

    // node index mapped onto the table address, widened or cut as the depth needs
    assign node_ext = EW'(source_node);
    assign in_addr  = node_ext[AW-1:0];
    assign in_range = (32'(source_node) < 32'(SOURCES));

    assign in_stall = (state_reg != pslm_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign rd_entry = pslm_pkg::pslm_entry_t'(ram_rdata);

    pslm_ram #(
        .WIDTH (TW),
        .DEPTH (SOURCES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (TW'(ram_wentry)),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    pslm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .lost     (div_lost),
        .sum      (div_sum),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // gap to the expected number, from one 33-bit subtract
    assign seq_diff  = {1'b0, seq_reg} - {1'b0, rd_entry.expected};
    assign seq_ahead = !seq_diff[SW];
    assign lost_add  = {1'b0, rd_entry.lost} + {1'b0, seq_diff[SW-1:0]};
    assign lost_sat  = lost_add[CW] ? '1 : lost_add[CW-1:0];
    assign recv_inc  = (&rd_entry.received) ? rd_entry.received
                                            : (rd_entry.received + CW'(1));

    // an out-of-range source reads as empty
    assign rd_lost_v = range_reg ? rd_entry.lost : '0;
    assign rd_recv_v = range_reg ? rd_entry.received : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pslm_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        node_reg     <= node_next;
        seq_reg      <= seq_next;
        range_reg    <= range_next;
        addr_reg     <= addr_next;
        rep_lost_reg <= rep_lost_next;
        rep_recv_reg <= rep_recv_next;
        empty_reg    <= empty_next;
        o_node_reg   <= o_node_next;
        o_lost_reg   <= o_lost_next;
        o_recv_reg   <= o_recv_next;
        o_frac_reg   <= o_frac_next;
        o_empty_reg  <= o_empty_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        mode_next      = mode_reg;
        node_next      = node_reg;
        seq_next       = seq_reg;
        range_next     = range_reg;
        addr_next      = addr_reg;
        rep_lost_next  = rep_lost_reg;
        rep_recv_next  = rep_recv_reg;
        empty_next     = empty_reg;
        o_node_next    = o_node_reg;
        o_lost_next    = o_lost_reg;
        o_recv_next    = o_recv_reg;
        o_frac_next    = o_frac_reg;
        o_empty_next   = o_empty_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wentry     = rd_entry;
        div_start      = 1'b0;
        div_lost       = rd_lost_v;
        div_sum        = {1'b0, rd_lost_v} + {1'b0, rd_recv_v};

        // the consumer taking the result frees the output register
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            pslm_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clr_idx_reg;
                ram_wentry = '0;
                if (clr_idx_reg == AW'(SOURCES - 1))
                begin
                    state_next = pslm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end

            pslm_pkg::ST_IDLE:
            begin
                // table read of the input's row is issued every cycle
                if (accept)
                begin
                    mode_next  = mode;
                    node_next  = source_node;
                    seq_next   = sequence_number;
                    range_next = in_range;
                    addr_next  = in_addr;
                    state_next = pslm_pkg::ST_READ;
                end
            end

            pslm_pkg::ST_READ:
            begin
                // row is here; write-back lands before the next accept, so a
                // following item on the same source always reads fresh data
                if (mode_reg == pslm_pkg::MODE_DATA)
                begin
                    ram_we = range_reg;
                    if (seq_ahead)
                    begin
                        ram_wentry.expected = seq_reg + SW'(1);
                        ram_wentry.lost     = lost_sat;
                        ram_wentry.received = recv_inc;
                    end
                    else
                    begin
                        // sender restarted its test, expected left alone
                        ram_wentry.lost     = seq_reg;
                        ram_wentry.received = CW'(1);
                    end
                    state_next = pslm_pkg::ST_IDLE;
                end
                else
                begin
                    rep_lost_next       = rd_lost_v;
                    rep_recv_next       = rd_recv_v;
                    empty_next          = (div_sum == '0);
                    div_start           = 1'b1;
                    // report clears expected and lost, received is kept
                    ram_we              = range_reg;
                    ram_wentry.expected = '0;
                    ram_wentry.lost     = '0;
                    state_next          = pslm_pkg::ST_DIV;
                end
            end

            pslm_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = pslm_pkg::ST_EMIT;
                end
            end

            pslm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_node_next    = node_reg;
                    o_lost_next    = rep_lost_reg;
                    o_recv_next    = rep_recv_reg;
                    o_frac_next    = empty_reg ? '0 : div_q;
                    o_empty_next   = empty_reg;
                    state_next     = pslm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pslm_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign report_node    = o_node_reg;
    assign lost_total     = o_lost_reg;
    assign received_total = o_recv_reg;
    assign loss_fraction  = o_frac_reg;
    assign no_packets     = o_empty_reg;

`ifndef SYNTHESIS
    // no item taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pslm_pkg::ST_CLEAR) |-> in_stall)
    else $error("item accepted during table clear");

    // divider finishes only while the controller waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == pslm_pkg::ST_DIV))
    else $error("divider finished outside divide state");

    // an empty report carries a zero fraction
    a_empty_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_packets) |-> (loss_fraction == '0))
    else $error("empty report with non-zero fraction");

    // fraction never exceeds 1.0
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (loss_fraction <= FW'(65536)))
    else $error("loss fraction above one");

    // a report with no received packets and some loss is a full loss
    a_full_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (received_total == '0) && (lost_total != '0))
            |-> (loss_fraction == FW'(65536)))
    else $error("all-lost report without full fraction");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the per-source sequence loss monitor against a cycle-free predictor
// of its loss table, with directed corner cases, random traffic and
// back-pressure on both channels
// ----------------------------------------------------------------------------
module testbench;

    localparam int NODES      = 64;
    localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int IDLE_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int TAIL_WAIT  = 40;    // settle time after the last result
    localparam int NUM_W      = pslm_pkg::CNT_W + 16;

    // one expected report item
    typedef struct packed {
        logic [pslm_pkg::NODE_W-1:0] node;
        logic [pslm_pkg::CNT_W-1:0]  lost;
        logic [pslm_pkg::CNT_W-1:0]  received;
        logic [pslm_pkg::FRAC_W-1:0] fraction;
        logic                        empty;
    } loss_report_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          mode;
    logic [pslm_pkg::NODE_W-1:0]   source_node;
    logic [pslm_pkg::SEQ_W-1:0]    sequence_number;
    logic                          out_valid;
    logic                          out_stall;
    logic [pslm_pkg::NODE_W-1:0]   report_node;
    logic [pslm_pkg::CNT_W-1:0]    lost_total;
    logic [pslm_pkg::CNT_W-1:0]    received_total;
    logic [pslm_pkg::FRAC_W-1:0]   loss_fraction;
    logic                          no_packets;

    // predicted loss table
    logic [pslm_pkg::SEQ_W-1:0]    next_seq_tbl [NODES];
    logic [pslm_pkg::CNT_W-1:0]    lost_tbl     [NODES];
    logic [pslm_pkg::CNT_W-1:0]    rcvd_tbl     [NODES];

    // reports still owed by the block, oldest first
    loss_report_t                  pending_reports [$];

    // sequence cursor per source, used only to shape the stimulus
    logic [pslm_pkg::SEQ_W-1:0]    seq_cursor [NODES];

    int                  error_count = 0;
    int                  idle_cycles = 0;
    bit                  tx_idle_on  = 1'b0;
    bit                  rx_idle_on  = 1'b0;
    int                  hold_requests = 0;

    always #5 clk = ~clk;

    per_source_sequence_loss_monitor #(
        .SOURCES (NODES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .source_node     (source_node),
        .sequence_number (sequence_number),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .report_node     (report_node),
        .lost_total      (lost_total),
        .received_total  (received_total),
        .loss_fraction   (loss_fraction),
        .no_packets      (no_packets)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // 32-bit add that sticks at the top instead of wrapping
    function automatic logic [pslm_pkg::CNT_W-1:0] sat_add(
        input logic [pslm_pkg::CNT_W-1:0] a,
        input logic [pslm_pkg::CNT_W-1:0] b);
        logic [pslm_pkg::CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[pslm_pkg::CNT_W] ? {pslm_pkg::CNT_W{1'b1}} : s[pslm_pkg::CNT_W-1:0];
    endfunction

    // apply one accepted item to the table, queue the report it causes
    function automatic void track_loss(input logic m,
                                       input logic [pslm_pkg::NODE_W-1:0] node,
                                       input logic [pslm_pkg::SEQ_W-1:0] seq);
        loss_report_t               rep;
        logic [pslm_pkg::SUM_W-1:0] sum;
        logic [NUM_W-1:0]           num;
        logic [NUM_W-1:0]           quo;
        if (m == pslm_pkg::MODE_DATA)
        begin
            if (seq >= next_seq_tbl[node])
            begin
                lost_tbl[node]     = sat_add(lost_tbl[node], seq - next_seq_tbl[node]);
                rcvd_tbl[node]     = sat_add(rcvd_tbl[node], pslm_pkg::CNT_W'(1));
                next_seq_tbl[node] = seq + pslm_pkg::SEQ_W'(1);
            end
            else
            begin
                // sender restarted its test: expected stays as it was
                lost_tbl[node] = seq;
                rcvd_tbl[node] = pslm_pkg::CNT_W'(1);
            end
        end
        else
        begin
            rep.node     = node;
            rep.lost     = lost_tbl[node];
            rep.received = rcvd_tbl[node];
            sum          = {1'b0, lost_tbl[node]} + {1'b0, rcvd_tbl[node]};
            rep.empty    = (sum == '0);
            if (rep.empty)
                rep.fraction = '0;
            else
            begin
                num          = {lost_tbl[node], 16'h0000};
                quo          = num / NUM_W'(sum);
                rep.fraction = quo[pslm_pkg::FRAC_W-1:0];
            end
            pending_reports.push_back(rep);
            // the report clears expected and lost but keeps received
            next_seq_tbl[node] = '0;
            lost_tbl[node]     = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // one process samples both channels at the edge: results are checked
    // first, then the accepted item updates the prediction, so ordering
    // within the step never matters
    always @(posedge clk)
    begin
        loss_report_t exp_rep;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                    report_error("unexpected result, node", 64'(report_node), 64'(0));
                else
                begin
                    exp_rep = pending_reports.pop_front();
                    if (report_node !== exp_rep.node)
                        report_error("report_node", 64'(report_node), 64'(exp_rep.node));
                    if (lost_total !== exp_rep.lost)
                        report_error("lost_total", 64'(lost_total), 64'(exp_rep.lost));
                    if (received_total !== exp_rep.received)
                        report_error("received_total", 64'(received_total),
                                     64'(exp_rep.received));
                    if (loss_fraction !== exp_rep.fraction)
                        report_error("loss_fraction", 64'(loss_fraction),
                                     64'(exp_rep.fraction));
                    if (no_packets !== exp_rep.empty)
                        report_error("no_packets", 64'(no_packets), 64'(exp_rep.empty));
                end
            end
            if (in_valid && !in_stall)
                track_loss(mode, source_node, sequence_number);

            // watchdog on handshake activity
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL per_source_sequence_loss_monitor");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side stall
    // ------------------------------------------------------------------------

    // random stall bursts, plus a long hold-off whenever one is requested
    initial
    begin
        int burst_left;
        int hold_left;
        int hold_served;
        burst_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        out_stall   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                burst_left = $urandom_range(1, 11) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // offer one item and wait until the block takes it
    task automatic send_item(input logic m, input logic [pslm_pkg::NODE_W-1:0] node,
                             input logic [pslm_pkg::SEQ_W-1:0] seq);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= m;
        source_node     <= node;
        sequence_number <= seq;
        do
            @(posedge clk);
        while (in_stall);
        // keep the stimulus cursor roughly in step with the block
        if (m == pslm_pkg::MODE_DATA)
            seq_cursor[node] = seq + pslm_pkg::SEQ_W'(1);
        else
            seq_cursor[node] = '0;
    endtask

    task automatic send_packet(input logic [pslm_pkg::NODE_W-1:0] node,
                               input logic [pslm_pkg::SEQ_W-1:0] seq);
        send_item(pslm_pkg::MODE_DATA, node, seq);
    endtask

    task automatic send_report(input logic [pslm_pkg::NODE_W-1:0] node);
        send_item(pslm_pkg::MODE_REPORT, node, $urandom);
    endtask

    // stop offering and let every owed report come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // report on a source that has never seen a packet
    task automatic test_empty_source();
        send_report(6'd0);
    endtask

    // gap-free stream gives zero loss
    task automatic test_in_order_stream();
        send_packet(6'd1, 32'd0);
        send_packet(6'd1, 32'd1);
        send_packet(6'd1, 32'd2);
        send_report(6'd1);
    endtask

    // skipped sequence numbers count as lost
    task automatic test_sequence_gaps();
        send_packet(6'd2, 32'd5);
        send_packet(6'd2, 32'd10);
        send_report(6'd2);
    endtask

    // lower sequence number restarts the count, also down to zero
    task automatic test_restarts();
        send_packet(6'd3, 32'd100);
        send_packet(6'd3, 32'd50);
        send_report(6'd3);
        send_packet(6'd4, 32'd7);
        send_packet(6'd4, 32'd0);
        send_report(6'd4);
    endtask

    // top sequence number wraps expected to zero, lost then saturates;
    // second report shows lost cleared and received kept
    task automatic test_saturation_and_wrap();
        send_packet(6'd5, 32'hFFFF_FFFF);
        send_packet(6'd5, 32'hFFFF_FFFE);
        send_report(6'd5);
        send_report(6'd5);
    endtask

    // highest source index
    task automatic test_top_node();
        send_packet(6'd63, 32'h8000_0000);
        send_packet(6'd63, 32'h8000_0003);
        send_report(6'd63);
    endtask

    // mostly well-formed streams on a few sources, with restarts, big jumps
    // and reports mixed in
    task automatic random_item();
        logic [pslm_pkg::NODE_W-1:0] node;
        logic [pslm_pkg::SEQ_W-1:0]  seq;
        int                          pick;
        node = ($urandom_range(0, 3) == 0)
                   ? pslm_pkg::NODE_W'($urandom_range(0, NODES - 1))
                   : pslm_pkg::NODE_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_report(node);
        else
        begin
            if (pick < 70)
                seq = seq_cursor[node] + $urandom_range(0, 2);
            else if (pick < 82)
                seq = seq_cursor[node] + $urandom_range(3, 60);
            else if (pick < 92)
                seq = seq_cursor[node] - $urandom_range(1, 60);
            else
                seq = $urandom;
            send_packet(node, seq);
        end
    endtask

    task automatic test_random_traffic(input int count, input bit idling);
        tx_idle_on = idling;
        rx_idle_on = idling;
        repeat (count) random_item();
    endtask

    // receiver holds off while reports keep coming, so the block backs up
    task automatic test_output_hold_off();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_requests++;
        repeat (50)
        begin
            if ($urandom_range(0, 1) == 0)
                send_report(pslm_pkg::NODE_W'($urandom_range(0, 7)));
            else
                random_item();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = pslm_pkg::MODE_DATA;
        source_node     = '0;
        sequence_number = '0;
        for (int i = 0; i < NODES; i++)
        begin
            next_seq_tbl[i] = '0;
            lost_tbl[i]     = '0;
            rcvd_tbl[i]     = '0;
            seq_cursor[i]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_source();
        test_in_order_stream();
        test_sequence_gaps();
        test_restarts();
        test_saturation_and_wrap();
        test_top_node();
        wait_drained();

        test_random_traffic(380, 1'b1);
        test_output_hold_off();
        // sender pauses until every owed report is out
        wait_drained();
        test_random_traffic(120, 1'b0);
        wait_drained();

        if (error_count == 0 && pending_reports.size() == 0)
            $display("PASS per_source_sequence_loss_monitor");
        else
            $display("FAIL per_source_sequence_loss_monitor");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pslm_pkg.sv
hw/rtl/pslm_ram.sv
hw/rtl/pslm_div.sv
hw/rtl/per_source_sequence_loss_monitor.sv
sim/testbench.sv
